// ----- hw/rtl/multi_channel_rate_timer_top_macros.svh -----
// Assertion macros used by the checker file
`ifndef MULTI_CHANNEL_RATE_TIMER_TOP_MACROS_SVH
`define MULTI_CHANNEL_RATE_TIMER_TOP_MACROS_SVH

// antecedent implies consequent, same cycle
`define MCRT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcrt assertion failed");

// expression holds on every clock edge out of reset
`define MCRT_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("mcrt assertion failed");

`endif

// ----- hw/rtl/mcrt_pkg.sv -----
// Types, constants and operation codes of the rate timer
package mcrt_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int MAX_RATE     = 1024;
   localparam int MIN_RATE     = 2;
   localparam int CNT_W        = $clog2(MAX_RATE + 1);
   localparam int OPEN_RATE_SHIFT = 1;   // open selects 2 Hz
   localparam logic [7:0] ONESHOT_TICKS_RESET = 8'd10;

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_OPEN     = 3'd1,
      OP_CLOSE    = 3'd2,
      OP_SET_RATE = 3'd3,
      OP_READ     = 3'd4,
      OP_OS_START = 3'd5,
      OP_OS_POLL  = 3'd6,
      OP_NOP      = 3'd7
   } op_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [1:0]  channel;
      logic [15:0] rate_value;
   } req_item_type;

   typedef struct packed {
      logic status;
      logic fired;
   } rsp_item_type;

   typedef struct packed {
      logic             tick;
      logic             open;
      logic             close;
      logic             set_rate;   // only when the rate passed its check
      logic             read;
      logic [1:0]       channel;
      logic [CNT_W-1:0] reload;
   } chan_cmd_type;

   typedef struct packed {
      logic       tick;
      logic       start;
      logic       poll;
      logic [7:0] ticks;
   } os_cmd_type;

endpackage

// ----- hw/rtl/mcrt_chan.sv -----
// Bank of periodic timer channels: enable, reload, down-counter, pending flag
module mcrt_chan import mcrt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  chan_cmd_type cmd,
   output logic         fired
);

   logic             enable_ff  [NUM_CHANNELS];
   logic             enable_in  [NUM_CHANNELS];
   logic [CNT_W-1:0] reload_ff  [NUM_CHANNELS];
   logic [CNT_W-1:0] reload_in  [NUM_CHANNELS];
   logic [CNT_W-1:0] count_ff   [NUM_CHANNELS];
   logic [CNT_W-1:0] count_in   [NUM_CHANNELS];
   logic             pending_ff [NUM_CHANNELS];
   logic             pending_in [NUM_CHANNELS];

   always_comb begin
      logic sel;
      fired = 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         sel = (int'(cmd.channel) == i);
         enable_in[i]  = enable_ff[i];
         reload_in[i]  = reload_ff[i];
         count_in[i]   = count_ff[i];
         pending_in[i] = pending_ff[i];
         if (cmd.tick && enable_ff[i]) begin
            if (count_ff[i] <= CNT_W'(1)) begin
               pending_in[i] = 1'b1;
               count_in[i]   = reload_ff[i];
            end else begin
               count_in[i] = count_ff[i] - CNT_W'(1);
            end
         end
         if (sel) begin
            if (cmd.open) begin
               reload_in[i]  = CNT_W'(MAX_RATE >> OPEN_RATE_SHIFT);
               count_in[i]   = CNT_W'(MAX_RATE >> OPEN_RATE_SHIFT);
               pending_in[i] = 1'b0;
               enable_in[i]  = 1'b1;
            end
            if (cmd.close) begin
               enable_in[i] = 1'b0;
            end
            if (cmd.set_rate) begin
               reload_in[i] = cmd.reload;
               count_in[i]  = cmd.reload;
            end
            if (cmd.read && pending_ff[i]) begin
               fired         = 1'b1;
               pending_in[i] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (reset) begin
            enable_ff[i]  <= 1'b0;
            reload_ff[i]  <= '0;
            count_ff[i]   <= '0;
            pending_ff[i] <= 1'b0;
         end else begin
            enable_ff[i]  <= enable_in[i];
            reload_ff[i]  <= reload_in[i];
            count_ff[i]   <= count_in[i];
            pending_ff[i] <= pending_in[i];
         end
      end
   end

endmodule

// ----- hw/rtl/mcrt_oneshot.sv -----
// One-shot timer: saturating down-counter with pending flag
module mcrt_oneshot import mcrt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  os_cmd_type cmd,
   output logic       fired
);

   logic       enable_ff;
   logic       enable_in;
   logic [7:0] count_ff;
   logic [7:0] count_in;
   logic       pending_ff;
   logic       pending_in;

   always_comb begin
      enable_in  = enable_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      fired      = 1'b0;
      if (cmd.tick && enable_ff) begin
         if (count_ff != 8'd0) begin
            count_in = count_ff - 8'd1;
         end
         if (count_ff <= 8'd1) begin
            pending_in = 1'b1;
         end
      end
      if (cmd.start) begin
         enable_in  = 1'b1;
         pending_in = 1'b0;
         count_in   = cmd.ticks;
      end
      if (cmd.poll && pending_ff) begin
         fired      = 1'b1;
         pending_in = 1'b0;
         enable_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         count_ff   <= 8'd0;
         pending_ff <= 1'b0;
      end else begin
         enable_ff  <= enable_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// ----- hw/rtl/multi_channel_rate_timer_top.sv -----
// Multi-channel rate timer: periodic channels and a one-shot on a common base tick
//
// Command channel: an item (op, channel, rate_value) is taken at a clock edge
// with start high and busy low. busy stays low, so an item may be issued in
// every cycle.
// Result channel: each item gives exactly one result (status, fired) shown on
// rsp_item for one cycle with rsp_valid high. rsp_valid rises at the edge after
// the one that took the item; the receiver takes the result while it is high.
// The receiver cannot hold results off.
// Throughput is one item per cycle: the item is registered, then decoded and
// applied to the channel and one-shot registers at the same edge at which the
// result register is loaded.
// Config port: csr_data loads the one-shot tick count at an edge with
// csr_valid and csr_ready; csr_ready is always high.
// Reset (synchronous, active high) disables all channels and the one-shot,
// clears all counts and flags, sets the one-shot tick count to 10 and drops
// any item in flight.
module multi_channel_rate_timer_top import mcrt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data
);

   req_item_type req_ff;
   logic         req_valid_ff;
   rsp_item_type rsp_ff;
   rsp_item_type rsp_in;
   logic         rsp_valid_ff;
   logic [7:0]   oneshot_ticks_ff;

   chan_cmd_type chan_cmd;
   os_cmd_type   os_cmd;
   logic         chan_fired;
   logic         os_fired;
   logic         rate_ok;
   logic [3:0]   rate_shift;
   logic [15:0]  rate;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // rate check: power of two inside MIN_RATE..MAX_RATE
   assign rate    = req_ff.rate_value;
   assign rate_ok = (rate >= 16'(MIN_RATE)) && (rate <= 16'(MAX_RATE)) &&
                    ((rate & (rate - 16'd1)) == 16'd0);

   always_comb begin
      rate_shift = 4'd0;
      for (int j = 0; j < 16; j++) begin
         if (rate[j]) begin
            rate_shift = 4'(j);
         end
      end
   end

   always_comb begin
      logic go;
      go = req_valid_ff;
      chan_cmd.tick     = go && (req_ff.op == OP_TICK);
      chan_cmd.open     = go && (req_ff.op == OP_OPEN);
      chan_cmd.close    = go && (req_ff.op == OP_CLOSE);
      chan_cmd.set_rate = go && (req_ff.op == OP_SET_RATE) && rate_ok;
      chan_cmd.read     = go && (req_ff.op == OP_READ);
      chan_cmd.channel  = req_ff.channel;
      chan_cmd.reload   = CNT_W'(MAX_RATE >> rate_shift);
      os_cmd.tick  = go && (req_ff.op == OP_TICK);
      os_cmd.start = go && (req_ff.op == OP_OS_START);
      os_cmd.poll  = go && (req_ff.op == OP_OS_POLL);
      os_cmd.ticks = oneshot_ticks_ff;
      rsp_in.status = (req_ff.op == OP_SET_RATE) && !rate_ok;
      rsp_in.fired  = chan_fired || os_fired;
   end

   mcrt_chan u_chan (
      .clock (clock),
      .reset (reset),
      .cmd   (chan_cmd),
      .fired (chan_fired)
   );

   mcrt_oneshot u_oneshot (
      .clock (clock),
      .reset (reset),
      .cmd   (os_cmd),
      .fired (os_fired)
   );

   always_ff @(posedge clock) begin
      req_ff <= req_item;
      rsp_ff <= rsp_in;
      if (reset) begin
         req_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         oneshot_ticks_ff <= ONESHOT_TICKS_RESET;
      end else begin
         req_valid_ff <= start && !busy;
         rsp_valid_ff <= req_valid_ff;
         if (csr_valid && csr_ready) begin
            oneshot_ticks_ff <= csr_data;
         end
      end
   end

endmodule

// ----- hw/rtl/mcrt_checker.sv -----
// Port-level checker for the rate timer, bound to the top level
`include "multi_channel_rate_timer_top_macros.svh"

module mcrt_checker import mcrt_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_item_type req_item,
   input logic         rsp_valid,
   input rsp_item_type rsp_item
);

   `MCRT_ASSERT_IMPL(a_one_rsp_per_item, clock, reset, start && !busy, ##2 rsp_valid)
   `MCRT_ASSERT_IMPL(a_reject_only_set_rate, clock, reset, rsp_valid && rsp_item.status,
      $past(req_item.op, 2) == OP_SET_RATE)
   `MCRT_ASSERT_IMPL(a_fired_only_read_poll, clock, reset, rsp_valid && rsp_item.fired,
      ($past(req_item.op, 2) == OP_READ) || ($past(req_item.op, 2) == OP_OS_POLL))
   `MCRT_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)

endmodule

bind multi_channel_rate_timer_top mcrt_checker u_mcrt_checker (.*);

// ----- dv/tb.sv -----
// Self-checking testbench for the multi-channel rate timer
module tb import mcrt_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int PRINT_LIMIT = 100;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_data = 8'd0;

   multi_channel_rate_timer_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the timer state
   logic             ch_enabled [NUM_CHANNELS];
   logic [CNT_W-1:0] ch_period  [NUM_CHANNELS];
   logic [CNT_W-1:0] ch_left    [NUM_CHANNELS];
   logic             ch_flag    [NUM_CHANNELS];
   logic             os_armed = 1'b0;
   logic [7:0]       os_left  = 8'd0;
   logic             os_flag  = 1'b0;
   logic [7:0]       os_ticks = ONESHOT_TICKS_RESET;

   req_item_type command_q[$];
   rsp_item_type outcome_q[$];
   int           mismatches = 0;
   int           gap_left = 0;
   bit           idle_on = 1'b1;
   int           quiet_cycles = 0;

   initial begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         ch_enabled[i] = 1'b0;
         ch_period[i]  = '0;
         ch_left[i]    = '0;
         ch_flag[i]    = 1'b0;
      end
   end

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("tb: mismatch at %0t ns: %s", $realtime, what);
   endtask

   function automatic void advance_tick();
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (ch_enabled[i]) begin
            if (ch_left[i] <= 1) begin
               ch_flag[i] = 1'b1;
               ch_left[i] = ch_period[i];
            end else begin
               ch_left[i] = ch_left[i] - 1'b1;
            end
         end
      end
      if (os_armed) begin
         if (os_left != 0)
            os_left = os_left - 1'b1;
         if (os_left == 0)
            os_flag = 1'b1;
      end
   endfunction

   // updates the shadow state and returns the status/fired pair the item yields
   function automatic rsp_item_type apply_command(input req_item_type cmd);
      rsp_item_type res;
      int           ch;
      int           r;
      bit           legal;
      res   = '0;
      ch    = int'(cmd.channel);
      r     = int'(cmd.rate_value);
      legal = (r >= MIN_RATE) && (r <= MAX_RATE) && ((r & (r - 1)) == 0);
      case (op_type'(cmd.op))
         OP_TICK: begin
            advance_tick();
         end
         OP_OPEN: begin
            if (ch < NUM_CHANNELS) begin
               ch_period[ch]  = CNT_W'(MAX_RATE >> OPEN_RATE_SHIFT);
               ch_left[ch]    = ch_period[ch];
               ch_flag[ch]    = 1'b0;
               ch_enabled[ch] = 1'b1;
            end
         end
         OP_CLOSE: begin
            if (ch < NUM_CHANNELS)
               ch_enabled[ch] = 1'b0;
         end
         OP_SET_RATE: begin
            if (!legal) begin
               res.status = 1'b1;
            end else if (ch < NUM_CHANNELS) begin
               ch_period[ch] = CNT_W'(MAX_RATE >> $clog2(r));
               ch_left[ch]   = ch_period[ch];
            end
         end
         OP_READ: begin
            if (ch < NUM_CHANNELS && ch_flag[ch]) begin
               res.fired   = 1'b1;
               ch_flag[ch] = 1'b0;
            end
         end
         OP_OS_START: begin
            os_armed = 1'b1;
            os_flag  = 1'b0;
            os_left  = os_ticks;
         end
         OP_OS_POLL: begin
            if (os_flag) begin
               res.fired = 1'b1;
               os_flag   = 1'b0;
               os_armed  = 1'b0;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic req_item_type make_item(input op_type op, input int ch,
                                              input int rate);
      req_item_type it;
      it.op         = op;
      it.channel    = 2'(ch);
      it.rate_value = 16'(rate);
      return it;
   endfunction

   // random item, weighted toward ticks and reads so that channels fire
   function automatic req_item_type random_item(input int start_pct);
      req_item_type it;
      int           pick;
      int           sel;
      it.channel    = 2'($urandom_range(0, 3));
      it.rate_value = 16'($urandom());
      pick          = $urandom_range(0, 99);
      if (pick < 12) begin
         it.op = OP_READ;
      end else if (pick < 22) begin
         it.op = OP_SET_RATE;
         sel   = $urandom_range(0, 9);
         if (sel < 4)
            it.rate_value = 16'(1 << $urandom_range(7, 10));
         else if (sel < 7)
            it.rate_value = 16'(1 << $urandom_range(1, 10));
         else if (sel == 7)
            it.rate_value = 16'($urandom_range(0, 1));
      end else if (pick < 28) begin
         it.op = OP_OPEN;
      end else if (pick < 32) begin
         it.op = OP_CLOSE;
      end else if (pick < 32 + start_pct) begin
         it.op = OP_OS_START;
      end else if (pick < 42 + start_pct) begin
         it.op = OP_OS_POLL;
      end else if (pick < 44 + start_pct) begin
         it.op = OP_NOP;
      end else begin
         it.op = OP_TICK;
      end
      return it;
   endfunction

   // driver: offers the next pending item, with random gaps
   always @(posedge clock) begin
      req_item_type nxt_item;
      logic         nxt_start;
      nxt_item  = req_item;
      nxt_start = start;
      if (reset) begin
         nxt_start = 1'b0;
      end else begin
         if (start && !busy) begin
            outcome_q.push_back(apply_command(req_item));
            nxt_start = 1'b0;
         end
         if (!nxt_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
               gap_left = $urandom_range(0, 10);
            end else if (command_q.size() != 0) begin
               nxt_item  = command_q.pop_front();
               nxt_start = 1'b1;
            end
         end
      end
      start    <= nxt_start;
      req_item <= nxt_item;
   end

   // monitor: compares each result with the oldest expected one
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid) begin
         if (outcome_q.size() == 0) begin
            flag_mismatch("result with no item outstanding");
         end else begin
            want = outcome_q.pop_front();
            if (rsp_item.status !== want.status)
               flag_mismatch($sformatf("status %b, expected %b", rsp_item.status,
                                       want.status));
            if (rsp_item.fired !== want.fired)
               flag_mismatch($sformatf("fired %b, expected %b", rsp_item.fired,
                                       want.fired));
         end
      end
   end

   // watchdog on cycles with no handshake of any kind
   always @(posedge clock) begin
      if (!reset && ((start && !busy) || rsp_valid || (csr_valid && csr_ready)))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic drain();
      while (command_q.size() != 0 || start || outcome_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_oneshot_ticks(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      os_ticks = value;
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random(input int count, input int start_pct);
      for (int i = 0; i < count; i++)
         command_q.push_back(random_item(start_pct));
   endtask

   initial begin
      logic [7:0] settings [5];
      int         counts   [5];
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: range checks, open/close, reads and the one-shot at its reset count
      command_q.push_back(make_item(OP_OPEN, 0, 0));
      command_q.push_back(make_item(OP_OPEN, 3, 16'hFFFF));
      command_q.push_back(make_item(OP_SET_RATE, 0, MAX_RATE));
      command_q.push_back(make_item(OP_SET_RATE, 3, MIN_RATE));
      command_q.push_back(make_item(OP_SET_RATE, 1, 0));
      command_q.push_back(make_item(OP_SET_RATE, 2, 1));
      command_q.push_back(make_item(OP_SET_RATE, 2, 3));
      command_q.push_back(make_item(OP_SET_RATE, 1, 2048));
      command_q.push_back(make_item(OP_SET_RATE, 2, 16'hFFFF));
      command_q.push_back(make_item(OP_READ, 0, 0));
      command_q.push_back(make_item(OP_OS_START, 0, 0));
      command_q.push_back(make_item(OP_TICK, 3, 16'hFFFF));
      command_q.push_back(make_item(OP_READ, 0, 0));
      command_q.push_back(make_item(OP_READ, 0, 0));
      command_q.push_back(make_item(OP_OS_POLL, 0, 0));
      command_q.push_back(make_item(OP_OPEN, 1, 0));
      command_q.push_back(make_item(OP_SET_RATE, 1, 512));
      command_q.push_back(make_item(OP_CLOSE, 0, 0));
      for (int i = 0; i < 9; i++)
         command_q.push_back(make_item(OP_TICK, 0, 0));
      command_q.push_back(make_item(OP_OS_POLL, 3, 16'hFFFF));
      command_q.push_back(make_item(OP_OS_POLL, 0, 0));
      command_q.push_back(make_item(OP_READ, 1, 0));
      command_q.push_back(make_item(OP_READ, 0, 0));
      command_q.push_back(make_item(OP_NOP, 3, 16'hFFFF));
      drain();

      settings = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 30)), 8'd3};
      counts   = '{150, 325, 200, 200, 200};
      for (int p = 0; p < 5; p++) begin
         idle_on = (p == 4) ? 1'b0 : ($urandom_range(0, 3) != 0);
         write_oneshot_ticks(settings[p]);
         command_q.push_back(make_item(OP_OS_START, 0, 0));
         if (settings[p] == 8'd255) begin
            // long count: no restarts, and a full pause halfway through
            queue_random(counts[p], 0);
            drain();
            queue_random(counts[p], 0);
         end else begin
            queue_random(counts[p], 4);
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (outcome_q.size() != 0)
         flag_mismatch("results still outstanding at end of run");
      if (mismatches == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/mcrt_pkg.sv
hw/rtl/mcrt_chan.sv
hw/rtl/mcrt_oneshot.sv
hw/rtl/multi_channel_rate_timer_top.sv
hw/rtl/mcrt_checker.sv
dv/tb.sv
